/* src/rlfc_pkg.sv */
// rlfc_pkg: shared types and codes for the rgb led flash controller
// no dependencies; imported by every rtl file of the block
`default_nettype none

package rlfc_pkg;

	localparam int unsigned LEN_W    = 16;
	localparam int unsigned PHASE_W  = 17;
	localparam int unsigned COLOR_W  = 3;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DATA_W = 16;

	localparam logic [LEN_W-1:0] DEFAULT_LENGTH = 16'd1000;
	localparam logic [LEN_W-1:0] PERIOD_SAT     = 16'hFFFF;

	typedef enum logic [1:0] {
		MODE_OFF   = 2'd0,
		MODE_SOLID = 2'd1,
		MODE_FLASH = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		REQ_TICK  = 2'd0,
		REQ_SOLID = 2'd1,
		REQ_FLASH = 2'd2,
		REQ_OFF   = 2'd3
	} req_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ON_LENGTH   = 3'd0,
		CFG_OFF_LENGTH  = 3'd1,
		CFG_FLASH_LIMIT = 3'd2,
		CFG_ON_COLOR    = 3'd3,
		CFG_OFF_COLOR   = 3'd4
	} cfg_idx_t;

	typedef struct packed {
		logic [LEN_W-1:0]   on_length;
		logic [LEN_W-1:0]   off_length;
		logic [LEN_W-1:0]   flash_limit;
		logic [COLOR_W-1:0] on_color;
		logic [COLOR_W-1:0] off_color;
	} cfg_t;

	typedef struct packed {
		mode_t              mode;
		logic [COLOR_W-1:0] led;
		logic [PHASE_W-1:0] phase;
		logic [LEN_W-1:0]   periods;
	} led_state_t;

endpackage

`default_nettype wire

/* src/rlfc_if.sv */
// rlfc_cmd_if / rlfc_status_if: valid-ready channels of the flash controller
// depends on rlfc_pkg for field widths
`default_nettype none

interface rlfc_cmd_if
	import rlfc_pkg::*;
	;
	logic               valid;
	logic               ready;
	logic [1:0]         req_type;
	logic [COLOR_W-1:0] solid_color;

	modport source (output valid, output req_type, output solid_color, input ready);
	modport sink   (input valid, input req_type, input solid_color, output ready);
endinterface

interface rlfc_status_if
	import rlfc_pkg::*;
	;
	logic               valid;
	logic               ready;
	logic [COLOR_W-1:0] led_bits;
	logic               is_active;
	logic               blinking;

	modport source (output valid, output led_bits, output is_active, output blinking,
		input ready);
	modport sink   (input valid, input led_bits, input is_active, input blinking,
		output ready);
endinterface

`default_nettype wire

/* src/rlfc_cfg_regs.sv */
// rlfc_cfg_regs: configuration register file of the flash controller
// depends on rlfc_pkg
`default_nettype none

module rlfc_cfg_regs
	import rlfc_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
	output cfg_t                       cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.on_length   <= DEFAULT_LENGTH;
			cfg_q.off_length  <= DEFAULT_LENGTH;
			cfg_q.flash_limit <= '0;
			cfg_q.on_color    <= '0;
			cfg_q.off_color   <= '0;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_ON_LENGTH:   cfg_q.on_length   <= cfg_wdata[LEN_W-1:0];
				CFG_OFF_LENGTH:  cfg_q.off_length  <= cfg_wdata[LEN_W-1:0];
				CFG_FLASH_LIMIT: cfg_q.flash_limit <= cfg_wdata[LEN_W-1:0];
				CFG_ON_COLOR:    cfg_q.on_color    <= cfg_wdata[COLOR_W-1:0];
				CFG_OFF_COLOR:   cfg_q.off_color   <= cfg_wdata[COLOR_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

/* src/rlfc_step.sv */
// rlfc_step: next-state logic for one command or tick
// depends on rlfc_pkg
`default_nettype none

module rlfc_step
	import rlfc_pkg::*;
(
	input  wire cfg_t                cfg,
	input  wire led_state_t          cur,
	input  wire logic [1:0]          req_type,
	input  wire logic [COLOR_W-1:0]  solid_color,
	output led_state_t               nxt
);

	logic [PHASE_W-1:0] period;
	logic [PHASE_W-1:0] phase_inc;
	logic               wrap;
	logic [LEN_W-1:0]   periods_inc;
	logic               limit_hit;

	always_comb begin
		period = {1'b0, cfg.on_length} + {1'b0, cfg.off_length};
		if (period == '0) begin
			period = PHASE_W'(1);
		end
		phase_inc   = cur.phase + PHASE_W'(1);
		wrap        = (phase_inc >= period);
		periods_inc = cur.periods;
		if (wrap && (cur.periods != PERIOD_SAT)) begin
			periods_inc = cur.periods + LEN_W'(1);
		end
		limit_hit = (cfg.flash_limit != '0) && (periods_inc >= cfg.flash_limit);
	end

	always_comb begin
		nxt = cur;
		case (req_t'(req_type))
			REQ_TICK: begin
				if (cur.mode == MODE_FLASH) begin
					nxt.phase   = wrap ? '0 : phase_inc;
					nxt.periods = periods_inc;
					if (limit_hit) begin
						nxt.mode = MODE_OFF;
						nxt.led  = '0;
					end else if (wrap || (phase_inc <= {1'b0, cfg.on_length})) begin
						nxt.led = cfg.on_color;
					end else begin
						nxt.led = cfg.off_color;
					end
				end
			end
			REQ_SOLID: begin
				if (solid_color != '0) begin
					nxt.mode = MODE_SOLID;
					nxt.led  = solid_color;
				end else begin
					nxt.mode = MODE_OFF;
					nxt.led  = '0;
				end
			end
			REQ_FLASH: begin
				nxt.mode    = MODE_FLASH;
				nxt.phase   = '0;
				nxt.periods = '0;
			end
			default: begin
				nxt.mode = MODE_OFF;
				nxt.led  = '0;
			end
		endcase
	end

endmodule

`default_nettype wire

/* src/rgb_led_flash_controller_core.sv */
// rgb_led_flash_controller_core: top level of the rgb led flash controller
// depends on rlfc_pkg, rlfc_if, rlfc_cfg_regs and rlfc_step
//
// Drives a three-bit RGB LED (bit0 red, bit1 green, bit2 blue) off, solid or
// flashing. Each item on cmd is a command (solid with a color, start flash,
// off) or a tick; every item produces exactly one item on status giving the
// LED drive and mode after it. An item is registered in the input register on
// acceptance; the mode and counter update and the result register load happen
// together when it advances, once the result slot is free or being emptied.
// The sustained rate is one item per clock while status is not stalled, set by
// the input register to result register pair. The input register takes one
// more item while a result waits; once both stages are full, cmd stalls.
// Flash timing counts ticks: a phase counter runs through on_length plus
// off_length ticks, and a saturating period counter stops flashing once
// flash_limit periods are done (zero means flash forever). Configuration is
// written through cfg_we/cfg_index/cfg_wdata and should only change while
// the block is idle.
`default_nettype none

module rgb_led_flash_controller_core
	import rlfc_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	rlfc_cmd_if.sink                   cmd,
	rlfc_status_if.source              status,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

	cfg_t cfg;

	// input register stage
	logic               valid_s1;
	logic [1:0]         req_s1;
	logic [COLOR_W-1:0] color_s1;

	// result register stage
	logic               valid_s2;
	logic [COLOR_W-1:0] led_s2;
	logic               active_s2;
	logic               flashing_s2;

	led_state_t state_q;
	led_state_t state_nxt;
	logic       advance;

	rlfc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	rlfc_step u_step (
		.cfg         (cfg),
		.cur         (state_q),
		.req_type    (req_s1),
		.solid_color (color_s1),
		.nxt         (state_nxt)
	);

	// the held item moves on once the result slot is free or being emptied
	assign advance   = valid_s1 && (!valid_s2 || status.ready);
	assign cmd.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	// payload of the input stage needs no reset
	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			req_s1   <= cmd.req_type;
			color_s1 <= cmd.solid_color;
		end
	end

	// mode and counters change only when an item completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.mode    <= MODE_OFF;
			state_q.led     <= '0;
			state_q.phase   <= '0;
			state_q.periods <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (status.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	// status reflects the state right after its item
	always_ff @(posedge clk) begin
		if (advance) begin
			led_s2      <= state_nxt.led;
			active_s2   <= (state_nxt.mode != MODE_OFF);
			flashing_s2 <= (state_nxt.mode == MODE_FLASH);
		end
	end

	assign status.valid     = valid_s2;
	assign status.led_bits  = led_s2;
	assign status.is_active = active_s2;
	assign status.blinking  = flashing_s2;

endmodule

`default_nettype wire

/* src/rlfc_checker.sv */
// rlfc_checker: port-level assertions for the flash controller, bound to the top
// depends on rlfc_pkg and rgb_led_flash_controller_core
`default_nettype none

module rlfc_checker
	import rlfc_pkg::*;
(
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               status_valid,
	input wire logic               status_ready,
	input wire logic [COLOR_W-1:0] led_bits,
	input wire logic               is_active,
	input wire logic               blinking
);

	// flashing is a kind of active
	a_flash_is_active: assert property (@(posedge clk) disable iff (!arst_n)
		status_valid |-> (is_active || !blinking))
		else $error("blinking without is_active");

	// an inactive block never drives the led
	a_off_is_dark: assert property (@(posedge clk) disable iff (!arst_n)
		(status_valid && !is_active) |-> (led_bits == '0))
		else $error("led driven while off");

	// a stalled status item holds
	a_status_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(status_valid && !status_ready) |=>
			(status_valid && $stable(led_bits) && $stable(is_active) && $stable(blinking)))
		else $error("status item changed while stalled");

endmodule

bind rgb_led_flash_controller_core rlfc_checker u_rlfc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.status_valid (status.valid),
	.status_ready (status.ready),
	.led_bits     (status.led_bits),
	.is_active    (status.is_active),
	.blinking     (status.blinking)
);

`default_nettype wire

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps
// tb_top: self-checking testbench for rgb_led_flash_controller_core
// needs rlfc_pkg, rlfc_if and the core rtl; runs a directed table, then random phases

module tb_top;
	import rlfc_pkg::*;

	typedef struct packed {
		logic [COLOR_W-1:0] led;
		logic               active;
		logic               flashing;
	} status_t;

	// one row of the directed table: a register write or an item, with an optional
	// hand-written expectation
	typedef struct packed {
		bit                  is_cfg;
		cfg_idx_t            idx;
		logic [LEN_W-1:0]    data;
		req_t                req;
		logic [COLOR_W-1:0]  color;
		bit                  typed;
		status_t             want;
	} step_t;

	localparam int DIR_ROWS    = 33;
	localparam int RAND_ITEMS  = 1050;
	localparam int HOLD_CYCLES = 64;
	localparam int DRAIN_WAIT  = 3;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	rlfc_cmd_if    cmd_ch ();
	rlfc_status_if status_ch ();

	rgb_led_flash_controller_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd_ch),
		.status    (status_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// shadow of the block: registers and flash state
	cfg_t               sim_cfg;
	mode_t              sim_mode;
	logic [COLOR_W-1:0] sim_led;
	logic [PHASE_W-1:0] sim_phase;
	logic [LEN_W-1:0]   sim_periods;

	status_t status_due [$];
	int      err_count;
	int      sent_items;
	int      idle_mode;

	// hand-written expectation of the item currently offered
	bit      typed_now;
	status_t typed_want;

	step_t directed_tbl [0:DIR_ROWS-1] = '{
		// after reset: tick does nothing, solid colors, zero color turns off
		'{1'b0, CFG_ON_LENGTH,   16'd0,     REQ_TICK,  3'd7, 1'b1, '{3'd0, 1'b0, 1'b0}},
		'{1'b0, CFG_ON_LENGTH,   16'd0,     REQ_SOLID, 3'd7, 1'b1, '{3'd7, 1'b1, 1'b0}},
		'{1'b0, CFG_ON_LENGTH,   16'd0,     REQ_SOLID, 3'd0, 1'b1, '{3'd0, 1'b0, 1'b0}},
		'{1'b0, CFG_ON_LENGTH,   16'd0,     REQ_SOLID, 3'd1, 1'b1, '{3'd1, 1'b1, 1'b0}},
		'{1'b0, CFG_ON_LENGTH,   16'd0,     REQ_TICK,  3'd0, 1'b1, '{3'd1, 1'b1, 1'b0}},
		// start flash keeps the drive until the next tick
		'{1'b0, CFG_ON_LENGTH,   16'd0,     REQ_FLASH, 3'd3, 1'b1, '{3'd1, 1'b1, 1'b1}},
		'{1'b0, CFG_ON_LENGTH,   16'd0,     REQ_TICK,  3'd6, 1'b0, '0},
		'{1'b0, CFG_ON_LENGTH,   16'd0,     REQ_OFF,   3'd5, 1'b1, '{3'd0, 1'b0, 1'b0}},
		'{1'b0, CFG_ON_LENGTH,   16'd0,     REQ_FLASH, 3'd0, 1'b1, '{3'd0, 1'b1, 1'b1}},
		'{1'b0, CFG_ON_LENGTH,   16'd0,     REQ_SOLID, 3'd4, 1'b1, '{3'd4, 1'b1, 1'b0}},
		'{1'b0, CFG_ON_LENGTH,   16'd0,     REQ_SOLID, 3'd2, 1'b1, '{3'd2, 1'b1, 1'b0}},
		'{1'b0, CFG_ON_LENGTH,   16'd0,     REQ_OFF,   3'd0, 1'b1, '{3'd0, 1'b0, 1'b0}},
		// zero period: every tick ends a period and shows the on color
		'{1'b1, CFG_ON_LENGTH,   16'd0,     REQ_TICK,  3'd0, 1'b0, '0},
		'{1'b1, CFG_OFF_LENGTH,  16'd0,     REQ_TICK,  3'd0, 1'b0, '0},
		'{1'b1, CFG_ON_COLOR,    16'd6,     REQ_TICK,  3'd0, 1'b0, '0},
		'{1'b1, CFG_OFF_COLOR,   16'd1,     REQ_TICK,  3'd0, 1'b0, '0},
		'{1'b0, CFG_ON_LENGTH,   16'd0,     REQ_FLASH, 3'd7, 1'b1, '{3'd0, 1'b1, 1'b1}},
		'{1'b0, CFG_ON_LENGTH,   16'd0,     REQ_TICK,  3'd1, 1'b0, '0},
		'{1'b0, CFG_ON_LENGTH,   16'd0,     REQ_TICK,  3'd2, 1'b0, '0},
		// limit reached on the next period boundary
		'{1'b1, CFG_FLASH_LIMIT, 16'd3,     REQ_TICK,  3'd0, 1'b0, '0},
		'{1'b0, CFG_ON_LENGTH,   16'd0,     REQ_TICK,  3'd3, 1'b0, '0},
		// zero on length: on color only at phase zero
		'{1'b1, CFG_OFF_LENGTH,  16'd2,     REQ_TICK,  3'd0, 1'b0, '0},
		'{1'b1, CFG_FLASH_LIMIT, 16'd0,     REQ_TICK,  3'd0, 1'b0, '0},
		'{1'b0, CFG_ON_LENGTH,   16'd0,     REQ_FLASH, 3'd5, 1'b0, '0},
		'{1'b0, CFG_ON_LENGTH,   16'd0,     REQ_TICK,  3'd0, 1'b0, '0},
		'{1'b0, CFG_ON_LENGTH,   16'd0,     REQ_TICK,  3'd0, 1'b0, '0},
		'{1'b0, CFG_ON_LENGTH,   16'd0,     REQ_TICK,  3'd0, 1'b0, '0},
		// largest lengths and limit
		'{1'b1, CFG_ON_LENGTH,   16'hFFFF,  REQ_TICK,  3'd0, 1'b0, '0},
		'{1'b1, CFG_OFF_LENGTH,  16'hFFFF,  REQ_TICK,  3'd0, 1'b0, '0},
		'{1'b1, CFG_FLASH_LIMIT, 16'hFFFF,  REQ_TICK,  3'd0, 1'b0, '0},
		'{1'b0, CFG_ON_LENGTH,   16'd0,     REQ_FLASH, 3'd2, 1'b0, '0},
		'{1'b0, CFG_ON_LENGTH,   16'd0,     REQ_TICK,  3'd4, 1'b0, '0},
		'{1'b0, CFG_ON_LENGTH,   16'd0,     REQ_OFF,   3'd1, 1'b1, '{3'd0, 1'b0, 1'b0}}
	};

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// gap drawn before each item: none, a uniform draw, or mostly none with rare gaps
	function automatic int draw_wait();
		case (idle_mode)
			0: return 0;
			1: return $urandom_range(0, 15);
			default: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 15) : 0;
		endcase
	endfunction

	// updates the shadow state for one accepted item and returns the led status after it
	function automatic status_t advance_led(req_t req, logic [COLOR_W-1:0] color);
		logic [PHASE_W-1:0] span;
		logic [PHASE_W-1:0] nxt;
		case (req)
			REQ_TICK: begin
				if (sim_mode == MODE_FLASH) begin
					span = {1'b0, sim_cfg.on_length} + {1'b0, sim_cfg.off_length};
					// zero period behaves as one tick
					if (span == '0)
						span = PHASE_W'(1);
					nxt = sim_phase + 1'b1;
					// phase may already sit past a shortened period
					if (nxt >= span) begin
						nxt = '0;
						if (sim_periods != PERIOD_SAT)
							sim_periods = sim_periods + 1'b1;
					end
					sim_phase = nxt;
					if (sim_cfg.flash_limit != '0 && sim_periods >= sim_cfg.flash_limit) begin
						sim_mode = MODE_OFF;
						sim_led  = '0;
					end else begin
						sim_led = (sim_phase <= {1'b0, sim_cfg.on_length}) ?
							sim_cfg.on_color : sim_cfg.off_color;
					end
				end
			end
			REQ_SOLID: begin
				if (color != '0) begin
					sim_mode = MODE_SOLID;
					sim_led  = color;
				end else begin
					sim_mode = MODE_OFF;
					sim_led  = '0;
				end
			end
			REQ_FLASH: begin
				sim_mode    = MODE_FLASH;
				sim_phase   = '0;
				sim_periods = '0;
			end
			default: begin
				sim_mode = MODE_OFF;
				sim_led  = '0;
			end
		endcase
		return '{sim_led, sim_mode != MODE_OFF, sim_mode == MODE_FLASH};
	endfunction

	task automatic flag_error(string msg);
		err_count++;
		$display("mismatch @%0t: %s", $realtime, msg);
	endtask

	// watcher: shadows register writes, predicts on each accepted item and checks each
	// accepted result against the oldest expectation
	always @(posedge clk) begin : watch
		status_t got;
		status_t want;
		status_t pred;
		if (!arst_n) begin
			sim_cfg     = '{DEFAULT_LENGTH, DEFAULT_LENGTH, 16'd0, 3'd0, 3'd0};
			sim_mode    = MODE_OFF;
			sim_led     = '0;
			sim_phase   = '0;
			sim_periods = '0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx_t'(cfg_index))
					CFG_ON_LENGTH:   sim_cfg.on_length   = cfg_wdata;
					CFG_OFF_LENGTH:  sim_cfg.off_length  = cfg_wdata;
					CFG_FLASH_LIMIT: sim_cfg.flash_limit = cfg_wdata;
					CFG_ON_COLOR:    sim_cfg.on_color    = cfg_wdata[COLOR_W-1:0];
					CFG_OFF_COLOR:   sim_cfg.off_color   = cfg_wdata[COLOR_W-1:0];
					default: ;
				endcase
			end
			if (cmd_ch.valid && cmd_ch.ready) begin
				pred = advance_led(req_t'(cmd_ch.req_type), cmd_ch.solid_color);
				// directed rows with a written-out answer are checked against that answer
				status_due.push_back(typed_now ? typed_want : pred);
			end
			if (status_ch.valid && status_ch.ready) begin
				got = '{status_ch.led_bits, status_ch.is_active, status_ch.blinking};
				if (status_due.size() == 0) begin
					flag_error("result with no item pending");
				end else begin
					want = status_due.pop_front();
					if (got.led !== want.led)
						flag_error($sformatf("led_bits %0d, expected %0d", got.led, want.led));
					if (got.active !== want.active)
						flag_error($sformatf("is_active %0b, expected %0b",
							got.active, want.active));
					if (got.flashing !== want.flashing)
						flag_error($sformatf("blinking %0b, expected %0b",
							got.flashing, want.flashing));
				end
			end
		end
	end

	// offer one item after a drawn gap and hold it until taken; called and returns at a
	// falling edge, valid stays high when the next item follows without a gap
	task automatic send_cmd(req_t req, logic [COLOR_W-1:0] color, bit typed, status_t want);
		int gap;
		gap = draw_wait();
		if (gap > 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		typed_now  = typed;
		typed_want = want;
		cmd_ch.valid       <= 1'b1;
		cmd_ch.req_type    <= req;
		cmd_ch.solid_color <= color;
		do @(posedge clk); while (!cmd_ch.ready);
		sent_items++;
		@(negedge clk);
	endtask

	// stop offering, let every result come back, then let the pipeline settle
	task automatic wait_drained();
		cmd_ch.valid <= 1'b0;
		while (status_due.size() != 0)
			@(negedge clk);
		repeat (DRAIN_WAIT) @(negedge clk);
	endtask

	// one register write per cycle; the caller drops cfg_we after the last one
	task automatic write_reg(cfg_idx_t idx, logic [LEN_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
	endtask

	// stimulus: directed table, then random phases of register settings and item bursts
	initial begin : stimulus
		bit               in_cfg;
		int               n;
		int               pick;
		logic [LEN_W-1:0] on_v;
		logic [LEN_W-1:0] off_v;
		logic [LEN_W-1:0] lim_v;
		req_t             req;

		arst_n             = 1'b0;
		cfg_we             = 1'b0;
		cfg_index          = '0;
		cfg_wdata          = '0;
		cmd_ch.valid       = 1'b0;
		cmd_ch.req_type    = REQ_TICK;
		cmd_ch.solid_color = '0;
		typed_now          = 1'b0;
		typed_want         = '0;
		err_count          = 0;
		sent_items         = 0;
		idle_mode          = 1;
		in_cfg             = 1'b0;

		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed part
		foreach (directed_tbl[i]) begin
			if (directed_tbl[i].is_cfg) begin
				if (!in_cfg)
					wait_drained();
				in_cfg = 1'b1;
				write_reg(directed_tbl[i].idx, directed_tbl[i].data);
			end else begin
				if (in_cfg)
					cfg_we <= 1'b0;
				in_cfg = 1'b0;
				send_cmd(directed_tbl[i].req, directed_tbl[i].color,
					directed_tbl[i].typed, directed_tbl[i].want);
			end
		end

		// random phases: new settings while idle, then a burst of mostly ticks
		while (sent_items < RAND_ITEMS) begin
			wait_drained();
			pick = $urandom_range(0, 19);
			if (pick < 13) begin
				// short periods so limits and boundaries come often
				on_v  = LEN_W'($urandom_range(0, 6));
				off_v = LEN_W'($urandom_range(0, 6));
				lim_v = LEN_W'($urandom_range(0, 4));
			end else if (pick < 16) begin
				on_v  = LEN_W'($urandom_range(0, 60));
				off_v = LEN_W'($urandom_range(0, 60));
				lim_v = LEN_W'($urandom_range(0, 3));
			end else if (pick < 18) begin
				// extremes of the ranges
				on_v  = $urandom_range(0, 1) ? 16'hFFFF : 16'd1;
				off_v = $urandom_range(0, 1) ? 16'hFFFF : 16'd0;
				lim_v = $urandom_range(0, 1) ? 16'hFFFF : 16'd0;
			end else begin
				// wide random values over the full register width
				on_v  = LEN_W'($urandom);
				off_v = LEN_W'($urandom);
				lim_v = LEN_W'($urandom);
			end
			if ($urandom_range(0, 3) != 0)
				write_reg(CFG_ON_LENGTH, on_v);
			if ($urandom_range(0, 3) != 0)
				write_reg(CFG_OFF_LENGTH, off_v);
			if ($urandom_range(0, 3) != 0)
				write_reg(CFG_FLASH_LIMIT, lim_v);
			if ($urandom_range(0, 1) != 0)
				write_reg(CFG_ON_COLOR, LEN_W'($urandom_range(0, 7)));
			if ($urandom_range(0, 1) != 0)
				write_reg(CFG_OFF_COLOR, LEN_W'($urandom_range(0, 7)));
			cfg_we <= 1'b0;
			idle_mode = $urandom_range(0, 2);

			// most bursts start a flash so ticks reach the period logic
			if (sim_mode != MODE_FLASH && $urandom_range(0, 4) != 0)
				send_cmd(REQ_FLASH, COLOR_W'($urandom_range(0, 7)), 1'b0, '0);
			n = $urandom_range(15, 50);
			repeat (n) begin
				pick = $urandom_range(0, 99);
				if (pick < 80)
					req = REQ_TICK;
				else if (pick < 88)
					req = REQ_FLASH;
				else if (pick < 95)
					req = REQ_SOLID;
				else
					req = REQ_OFF;
				send_cmd(req, COLOR_W'($urandom_range(0, 7)), 1'b0, '0);
			end
		end

		wait_drained();
		repeat (4) @(posedge clk);
		if (err_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// result side: random stalls per item, plus a long hold-off every few hundred
	// results while an item is offered so both pipeline stages fill and cmd stalls
	initial begin : receiver
		int stall;
		int rx_items;
		int next_hold;
		bit hold_due;
		status_ch.ready = 1'b0;
		rx_items  = 0;
		next_hold = 200;
		hold_due  = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			stall = hold_due ? HOLD_CYCLES : draw_wait();
			hold_due = 1'b0;
			if (stall > 0) begin
				status_ch.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			status_ch.ready <= 1'b1;
			do @(posedge clk); while (!status_ch.valid);
			rx_items++;
			if (rx_items >= next_hold && cmd_ch.valid) begin
				hold_due  = 1'b1;
				next_hold = rx_items + 300;
			end
			@(negedge clk);
		end
	end

	// run limit, many times the slowest expected run
	initial begin : watchdog
		#2_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule

/* sim.f */
src/rlfc_pkg.sv
src/rlfc_if.sv
src/rlfc_cfg_regs.sv
src/rlfc_step.sv
src/rgb_led_flash_controller_core.sv
src/rlfc_checker.sv
tb/sv/tb_top.sv
